FILE: hdl/sqvs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex setup package
// Shared constants, register indexes, the arctangent table and the
// saturation helper used by the vertex setup block.
// ----------------------------------------------------------------------------
package sqvs_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_M11 = 3'd0;
	localparam logic [2:0] REG_M12 = 3'd1;
	localparam logic [2:0] REG_M21 = 3'd2;
	localparam logic [2:0] REG_M22 = 3'd3;
	localparam logic [2:0] REG_TX  = 3'd4;
	localparam logic [2:0] REG_TY  = 3'd5;

	// Command codes.
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_DRAW  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// Register reset values (Q16.16 identity).
	localparam logic [31:0] XFORM_ONE  = 32'h0001_0000;
	localparam logic [31:0] XFORM_ZERO = 32'h0000_0000;

	// Saturation limits.
	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// Divider sizing: dividend magnitude width (also the iteration count) and divisor width.
	localparam int DIV_NUM_W = 49;
	localparam int DIV_DEN_W = 16;

	// CORDIC angles in Q.28 and the gain-compensated start value in Q2.30.
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_STEPS = 28;
	localparam logic signed [CORDIC_W-1:0] ANG_PI      = 34'sd843314857;
	localparam logic signed [CORDIC_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
	localparam logic signed [CORDIC_W-1:0] ANG_HALF_PI = 34'sd421657428;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [27:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
		28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
		28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
		28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
		28'd32, 28'd16, 28'd8, 28'd4, 28'd2
	};

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (!v[65] && (|v[64:31])) begin
			r = SAT_MAX;
		end else if (v[65] && !(&v[64:31])) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/sprite_quad_vertex_setup.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex setup
// Turns draw and end commands into vertex beats; begin opens a batch. One shared
// multiplier, a radix-2 divider and a CORDIC stage run under a sequencer.
// ----------------------------------------------------------------------------
// A draw runs eight 49-step divisions, which dominate its run time, then the
// CORDIC angle reduction and iterations, then emits its four vertices in turn.
// Begin only opens a batch; end and a draw outside a batch each give one beat.
// Reset clears the batch state and loads the identity transform.
module sprite_quad_vertex_setup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [15:0]        texture_id,
	input  logic [31:0]        tex_size,
	input  logic [31:0]        dst_pos,
	input  logic [31:0]        dst_size,
	input  logic [31:0]        src_pos,
	input  logic [31:0]        src_size,
	input  logic [31:0]        color_rgba,
	input  logic signed [15:0] rotation,
	input  logic [31:0]        origin,
	input  logic [1:0]         flip,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               flush,
	output logic               error,
	output logic [15:0]        vertex_index,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] tex_u,
	output logic signed [31:0] tex_v,
	output logic [31:0]        vertex_color,
	output logic               last
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ONE   = 4'd1;
	localparam logic [3:0] ST_QMUL  = 4'd2;
	localparam logic [3:0] ST_DSET  = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_DEND  = 4'd5;
	localparam logic [3:0] ST_CRED  = 4'd6;
	localparam logic [3:0] ST_CITER = 4'd7;
	localparam logic [3:0] ST_CFIN  = 4'd8;
	localparam logic [3:0] ST_VTX   = 4'd9;
	localparam logic [3:0] ST_EMIT  = 4'd10;

	localparam int NW = sqvs_pkg::DIV_NUM_W;
	localparam int DW = sqvs_pkg::DIV_DEN_W;
	localparam int CW = sqvs_pkg::CORDIC_W;

	logic [3:0] state_q;

	// Batch state.
	logic        batch_open_q;
	logic [15:0] vertex_count_q;
	logic [15:0] bound_texture_q;
	logic        texture_bound_q;

	// Transform registers.
	logic signed [31:0] m11_q, m12_q, m21_q, m22_q, tx_q, ty_q;

	// Latched draw fields.
	logic [31:0] tex_size_q, dst_pos_q, dst_size_q, src_pos_q, src_size_q;
	logic [31:0] color_q, origin_q;
	logic [1:0]  flip_q;
	logic        fl_first_q;
	logic [15:0] base_q;
	logic        one_flush_q, one_err_q;

	// Sequencer counters.
	logic [2:0] job_q;
	logic [1:0] rcnt_q;
	logic [1:0] vk_q;
	logic [3:0] vstep_q;

	// Division results.
	logic signed [31:0] u_lo_q, u_hi_q, v_lo_q, v_hi_q;
	logic signed [31:0] qx0_q, qx1_q, qy0_q, qy1_q;

	// Divider.
	logic [DW-1:0] dv_rem_q, dv_den_q;
	logic [NW-1:0] dv_quo_q;
	logic [5:0]    dv_cnt_q;
	logic          dv_qneg_q, dv_nneg_q, dv_nzero_q, dv_dzero_q;

	// CORDIC.
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [4:0]           ccnt_q;
	logic                 cneg_q;
	logic signed [31:0]   cs_q, sn_q;

	// Multiplier and accumulator.
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] rx_q, ry_q, ox_q, oy_q;

	// Field views.
	logic signed [15:0] src_x, src_y, src_w, src_h, dx, dy, dw, dh, org_x, org_y;
	logic [15:0]        tw, th;
	assign src_x = src_pos_q[31:16];
	assign src_y = src_pos_q[15:0];
	assign src_w = src_size_q[31:16];
	assign src_h = src_size_q[15:0];
	assign dx    = dst_pos_q[31:16];
	assign dy    = dst_pos_q[15:0];
	assign dw    = dst_size_q[31:16];
	assign dh    = dst_size_q[15:0];
	assign org_x = origin_q[31:16];
	assign org_y = origin_q[15:0];
	assign tw    = tex_size_q[31:16];
	assign th    = tex_size_q[15:0];

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Per-corner quotient selection.
	logic signed [31:0] qx_sel, qy_sel;
	assign qx_sel = (vk_q == 2'd1 || vk_q == 2'd2) ? qx1_q : qx0_q;
	assign qy_sel = vk_q[1] ? qy1_q : qy0_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		logic signed [31:0] corner, org;
		corner = '0;
		org    = '0;
		mul_a  = '0;
		mul_b  = '0;
		if (state_q == ST_QMUL) begin
			if (job_q[1]) begin
				corner = job_q[0] ? {{12{src_h[15]}}, src_h, 4'h0} : '0;
				org    = {{16{org_y[15]}}, org_y};
				mul_b  = {{16{dh[15]}}, dh};
			end else begin
				corner = job_q[0] ? {{12{src_w[15]}}, src_w, 4'h0} : '0;
				org    = {{16{org_x[15]}}, org_x};
				mul_b  = {{16{dw[15]}}, dw};
			end
			mul_a = corner - org;
		end else if (state_q == ST_VTX) begin
			unique case (vstep_q)
				4'd0: begin mul_a = qx_sel; mul_b = cs_q; end
				4'd1: begin mul_a = qy_sel; mul_b = sn_q; end
				4'd2: begin mul_a = qx_sel; mul_b = sn_q; end
				4'd3: begin mul_a = qy_sel; mul_b = cs_q; end
				4'd5: begin mul_a = rx_q;   mul_b = m11_q; end
				4'd6: begin mul_a = ry_q;   mul_b = m21_q; end
				4'd7: begin mul_a = rx_q;   mul_b = m12_q; end
				4'd8: begin mul_a = ry_q;   mul_b = m22_q; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	// Dividend and divisor for the current division job.
	logic signed [49:0] dv_num;
	logic signed [16:0] dv_den;
	always_comb begin
		logic signed [16:0] edge_sum;
		edge_sum = '0;
		dv_num   = '0;
		dv_den   = '0;
		if (job_q[2]) begin
			dv_num = {mul_p_q[37:0], 12'h000};
			dv_den = job_q[1] ? {src_h[15], src_h} : {src_w[15], src_w};
		end else begin
			if (job_q[1]) begin
				edge_sum = job_q[0] ? ({src_y[15], src_y} + {src_h[15], src_h})
				                    : {src_y[15], src_y};
				dv_den   = {1'b0, th};
			end else begin
				edge_sum = job_q[0] ? ({src_x[15], src_x} + {src_w[15], src_w})
				                    : {src_x[15], src_x};
				dv_den   = {1'b0, tw};
			end
			dv_num = {{17{edge_sum[16]}}, edge_sum, 16'h0000};
		end
	end

	logic [49:0] dv_num_abs;
	logic [16:0] dv_den_abs;
	assign dv_num_abs = dv_num[49] ? (~dv_num + 50'd1) : dv_num;
	assign dv_den_abs = dv_den[16] ? (~dv_den + 17'd1) : dv_den;

	// One restoring divider step.
	logic [DW:0]   dv_sh, dv_diff;
	logic          dv_ge;
	assign dv_sh   = {dv_rem_q, dv_quo_q[NW-1]};
	assign dv_ge   = dv_sh >= {1'b0, dv_den_q};
	assign dv_diff = dv_sh - {1'b0, dv_den_q};

	// Signed, saturated quotient.
	logic [31:0] dv_res;
	always_comb begin
		if (dv_dzero_q) begin
			dv_res = dv_nzero_q ? 32'h0 : (dv_nneg_q ? sqvs_pkg::SAT_MIN : sqvs_pkg::SAT_MAX);
		end else if (!dv_qneg_q) begin
			dv_res = (|dv_quo_q[NW-1:31]) ? sqvs_pkg::SAT_MAX : dv_quo_q[31:0];
		end else if ((|dv_quo_q[NW-1:32]) || (dv_quo_q[31] && (|dv_quo_q[30:0]))) begin
			dv_res = sqvs_pkg::SAT_MIN;
		end else begin
			dv_res = ~dv_quo_q[31:0] + 32'd1;
		end
	end

	// CORDIC step terms.
	logic signed [CW-1:0] c_xs, c_ys, c_at, cs_full, sn_full;
	assign c_xs    = cx_q >>> ccnt_q;
	assign c_ys    = cy_q >>> ccnt_q;
	assign c_at    = {6'h00, sqvs_pkg::ATAN_TAB[ccnt_q]};
	assign cs_full = cneg_q ? -cx_q : cx_q;
	assign sn_full = cneg_q ? -cy_q : cy_q;

	// Extended product and rotated sums.
	logic signed [65:0] p_ext, p_sh16, rx_sum, ry_sum;
	assign p_ext  = {{2{mul_p_q[63]}}, mul_p_q};
	assign p_sh16 = {{18{mul_p_q[63]}}, mul_p_q[63:16]};
	assign rx_sum = $signed({{34{dx[15]}}, dx, 16'h0000}) + (acc_q >>> 30);
	assign ry_sum = $signed({{34{dy[15]}}, dy, 16'h0000}) + (acc_q >>> 30);

	// Flip swaps on texture edges.
	logic signed [31:0] u_a, u_b, v_a, v_b;
	assign u_a = flip_q[0] ? u_hi_q : u_lo_q;
	assign u_b = flip_q[0] ? u_lo_q : u_hi_q;
	assign v_a = flip_q[1] ? v_hi_q : v_lo_q;
	assign v_b = flip_q[1] ? v_lo_q : v_hi_q;

	// Shared multiplier, registered.
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m11_q <= sqvs_pkg::XFORM_ONE;
			m12_q <= sqvs_pkg::XFORM_ZERO;
			m21_q <= sqvs_pkg::XFORM_ZERO;
			m22_q <= sqvs_pkg::XFORM_ONE;
			tx_q  <= sqvs_pkg::XFORM_ZERO;
			ty_q  <= sqvs_pkg::XFORM_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sqvs_pkg::REG_M11: m11_q <= cfg_data;
				sqvs_pkg::REG_M12: m12_q <= cfg_data;
				sqvs_pkg::REG_M21: m21_q <= cfg_data;
				sqvs_pkg::REG_M22: m22_q <= cfg_data;
				sqvs_pkg::REG_TX:  tx_q  <= cfg_data;
				sqvs_pkg::REG_TY:  ty_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with batch state and the output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			batch_open_q    <= 1'b0;
			vertex_count_q  <= '0;
			bound_texture_q <= '0;
			texture_bound_q <= 1'b0;
			out_valid       <= 1'b0;
			job_q           <= '0;
			rcnt_q          <= '0;
			vk_q            <= '0;
			vstep_q         <= '0;
			dv_cnt_q        <= '0;
			ccnt_q          <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (cmd)
							sqvs_pkg::CMD_BEGIN: batch_open_q <= 1'b1;
							sqvs_pkg::CMD_END: begin
								one_flush_q     <= texture_bound_q;
								one_err_q       <= 1'b0;
								texture_bound_q <= 1'b0;
								vertex_count_q  <= '0;
								batch_open_q    <= 1'b0;
								state_q         <= ST_ONE;
							end
							sqvs_pkg::CMD_DRAW: begin
								if (!batch_open_q) begin
									one_flush_q <= 1'b0;
									one_err_q   <= 1'b1;
									state_q     <= ST_ONE;
								end else begin
									if (texture_bound_q && bound_texture_q != texture_id) begin
										fl_first_q     <= 1'b1;
										base_q         <= '0;
										vertex_count_q <= 16'd4;
									end else begin
										fl_first_q     <= 1'b0;
										base_q         <= vertex_count_q;
										vertex_count_q <= vertex_count_q + 16'd4;
									end
									bound_texture_q <= texture_id;
									texture_bound_q <= 1'b1;
									tex_size_q      <= tex_size;
									dst_pos_q       <= dst_pos;
									dst_size_q      <= dst_size;
									src_pos_q       <= src_pos;
									src_size_q      <= src_size;
									color_q         <= color_rgba;
									origin_q        <= origin;
									flip_q          <= flip;
									cz_q            <= {{2{rotation[15]}}, rotation, 16'h0000};
									cx_q            <= sqvs_pkg::CORDIC_GAIN;
									cy_q            <= '0;
									cneg_q          <= 1'b0;
									job_q           <= '0;
									state_q         <= ST_DSET;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ONE: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						flush        <= one_flush_q;
						error        <= one_err_q;
						vertex_index <= '0;
						pos_x        <= '0;
						pos_y        <= '0;
						tex_u        <= '0;
						tex_v        <= '0;
						vertex_color <= '0;
						last         <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_QMUL: state_q <= ST_DSET;
				ST_DSET: begin
					dv_rem_q   <= '0;
					dv_quo_q   <= dv_num_abs[NW-1:0];
					dv_den_q   <= dv_den_abs[DW-1:0];
					dv_qneg_q  <= dv_num[49] ^ dv_den[16];
					dv_nneg_q  <= dv_num[49];
					dv_nzero_q <= (dv_num == '0);
					dv_dzero_q <= (dv_den == '0);
					dv_cnt_q   <= '0;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					dv_rem_q <= dv_ge ? dv_diff[DW-1:0] : dv_sh[DW-1:0];
					dv_quo_q <= {dv_quo_q[NW-2:0], dv_ge};
					dv_cnt_q <= dv_cnt_q + 6'd1;
					if (dv_cnt_q == 6'(NW - 1)) begin
						state_q <= ST_DEND;
					end
				end
				ST_DEND: begin
					unique case (job_q)
						3'd0: u_lo_q <= dv_res;
						3'd1: u_hi_q <= dv_res;
						3'd2: v_lo_q <= dv_res;
						3'd3: v_hi_q <= dv_res;
						3'd4: qx0_q  <= dv_res;
						3'd5: qx1_q  <= dv_res;
						3'd6: qy0_q  <= dv_res;
						3'd7: qy1_q  <= dv_res;
						default: ;
					endcase
					job_q <= job_q + 3'd1;
					if (job_q == 3'd7) begin
						rcnt_q  <= '0;
						state_q <= ST_CRED;
					end else if (job_q >= 3'd3) begin
						state_q <= ST_QMUL;
					end else begin
						state_q <= ST_DSET;
					end
				end
				ST_CRED: begin
					// Two full-turn reductions, then the half-turn fold.
					rcnt_q <= rcnt_q + 2'd1;
					if (rcnt_q != 2'd2) begin
						if (cz_q > sqvs_pkg::ANG_PI) begin
							cz_q <= cz_q - sqvs_pkg::ANG_TWO_PI;
						end else if (cz_q < -sqvs_pkg::ANG_PI) begin
							cz_q <= cz_q + sqvs_pkg::ANG_TWO_PI;
						end
					end else begin
						if (cz_q > sqvs_pkg::ANG_HALF_PI) begin
							cz_q   <= cz_q - sqvs_pkg::ANG_PI;
							cneg_q <= 1'b1;
						end else if (cz_q < -sqvs_pkg::ANG_HALF_PI) begin
							cz_q   <= cz_q + sqvs_pkg::ANG_PI;
							cneg_q <= 1'b1;
						end
						ccnt_q  <= '0;
						state_q <= ST_CITER;
					end
				end
				ST_CITER: begin
					if (!cz_q[CW-1]) begin
						cx_q <= cx_q - c_ys;
						cy_q <= cy_q + c_xs;
						cz_q <= cz_q - c_at;
					end else begin
						cx_q <= cx_q + c_ys;
						cy_q <= cy_q - c_xs;
						cz_q <= cz_q + c_at;
					end
					ccnt_q <= ccnt_q + 5'd1;
					if (ccnt_q == 5'(sqvs_pkg::CORDIC_STEPS - 1)) begin
						state_q <= ST_CFIN;
					end
				end
				ST_CFIN: begin
					cs_q    <= cs_full[31:0];
					sn_q    <= sn_full[31:0];
					vk_q    <= '0;
					vstep_q <= '0;
					state_q <= ST_VTX;
				end
				ST_VTX: begin
					// Rotate the corner, then apply the affine transform.
					vstep_q <= vstep_q + 4'd1;
					unique case (vstep_q)
						4'd1: acc_q <= p_ext;
						4'd2: acc_q <= acc_q - p_ext;
						4'd3: begin
							rx_q  <= sqvs_pkg::sat32(rx_sum);
							acc_q <= p_ext;
						end
						4'd4: acc_q <= acc_q + p_ext;
						4'd5: ry_q <= sqvs_pkg::sat32(ry_sum);
						4'd6: acc_q <= p_sh16;
						4'd7: acc_q <= acc_q + p_sh16;
						4'd8: begin
							ox_q  <= sqvs_pkg::sat32(acc_q + {{34{tx_q[31]}}, tx_q});
							acc_q <= p_sh16;
						end
						4'd9: acc_q <= acc_q + p_sh16;
						4'd10: begin
							oy_q    <= sqvs_pkg::sat32(acc_q + {{34{ty_q[31]}}, ty_q});
							state_q <= ST_EMIT;
						end
						default: ;
					endcase
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						flush        <= (vk_q == 2'd0) && fl_first_q;
						error        <= 1'b0;
						vertex_index <= base_q + {14'h0000, vk_q};
						pos_x        <= ox_q;
						pos_y        <= oy_q;
						tex_u        <= (vk_q == 2'd1 || vk_q == 2'd2) ? u_b : u_a;
						tex_v        <= vk_q[1] ? v_b : v_a;
						vertex_color <= color_q;
						last         <= (vk_q == 2'd3);
						vk_q         <= vk_q + 2'd1;
						vstep_q      <= '0;
						state_q      <= (vk_q == 2'd3) ? ST_IDLE : ST_VTX;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
